// File: rtl/bws_pkg.sv
// Package for the breath waveform sequencer: item structs, function and phase codes,
// fixed-point constants for the start computation and the hold-time bundle.
// No dependencies.
package bws_pkg;

  // Function codes carried by an input item.
  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_STOP  = 2'd2;

  // Waveform phase codes as reported in a result item.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RISE    = 3'd1;
  localparam logic [2:0] PH_PLATEAU = 3'd2;
  localparam logic [2:0] PH_FALL    = 3'd3;
  localparam logic [2:0] PH_PAUSE   = 3'd4;

  // Default duty levels.
  localparam logic [5:0] DUTY_LOW_DEF  = 6'd30;
  localparam logic [5:0] DUTY_HIGH_DEF = 6'd47;
  localparam logic [5:0] DUTY_DROP_DEF = 6'd37;

  // Q16 constants: knob divisor 6.7105, period numerator 60000 ms and the hold factors.
  localparam logic [18:0] Q_DIVISOR     = 19'd439779;
  localparam logic [31:0] PERIOD_NUM_Q  = 32'd3932160000;
  localparam logic [14:0] Q_RISE        = 15'd809;
  localparam logic [14:0] Q_PLATEAU     = 15'd9175;
  localparam logic [14:0] Q_FALL        = 15'd2902;
  localparam logic [14:0] Q_PAUSE       = 15'd17039;
  localparam logic [5:0]  RATE_BASE     = 6'd12;

  // Iteration counts of the serial divider and multiplier.
  localparam int RATE_STEPS   = 6;
  localparam int PERIOD_STEPS = 32;
  localparam int MUL_STEPS    = 15;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] knob_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0] duty;
    logic       running;
    logic [2:0] phase;
    logic [5:0] breath_rate;
  } out_item_t;

  // Rate and hold times produced by a start.
  typedef struct packed {
    logic [5:0]  rate;
    logic [6:0]  rise_step_ms;
    logic [9:0]  plateau_ms;
    logic [7:0]  fall_step_ms;
    logic [10:0] pause_ms;
  } hold_set_t;

endpackage

// File: rtl/bws_start_calc.sv
// Start computation: bit-serial restoring divider for rate and period, then a
// bit-serial multiplier that forms the four hold times. Depends on bws_pkg.
module bws_start_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        sample,
  output logic              done,
  output bws_pkg::hold_set_t holds
);

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_RATE   = 4'b0010,
    C_PERIOD = 4'b0100,
    C_MUL    = 4'b1000
  } calc_state_t;

  calc_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;

  // Divider registers: partial remainder, dividend shift line, quotient, divisor.
  logic [18:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [18:0] dvs_r, dvs_nxt;
  logic [5:0]  rate_r, rate_nxt;

  // Multiplier accumulators, one lane per hold factor.
  logic [28:0] acc_rise_r, acc_rise_nxt;
  logic [28:0] acc_plat_r, acc_plat_nxt;
  logic [28:0] acc_fall_r, acc_fall_nxt;
  logic [28:0] acc_paus_r, acc_paus_nxt;

  logic [19:0] trial;
  logic        qbit;
  logic [18:0] rem_step;
  logic [31:0] quo_step;
  logic [5:0]  rate_step;
  logic [3:0]  bit_idx;
  logic [28:0] per;

  // One restoring division step.
  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    qbit     = (trial >= {1'b0, dvs_r});
    rem_step = qbit ? 19'(trial - {1'b0, dvs_r}) : trial[18:0];
    quo_step = {quo_r[30:0], qbit};
    rate_step = 6'(bws_pkg::RATE_BASE + quo_step[5:0]);
  end

  assign bit_idx = cnt_r[3:0];
  assign per     = quo_r[28:0];

  // Shift-and-add lane: acc = floor((acc + bit * period) / 2).
  function automatic logic [28:0] mul_step(input logic [28:0] acc, input logic [28:0] p,
                                           input logic b);
    logic [29:0] sum;
    sum = {1'b0, acc} + (b ? {1'b0, p} : 30'd0);
    return sum[29:1];
  endfunction

  // Sequencer of the three serial passes.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    done_nxt     = 1'b0;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    quo_nxt      = quo_r;
    dvs_nxt      = dvs_r;
    rate_nxt     = rate_r;
    acc_rise_nxt = acc_rise_r;
    acc_plat_nxt = acc_plat_r;
    acc_fall_nxt = acc_fall_r;
    acc_paus_nxt = acc_paus_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          // Quotient of sample * 2^16 by the divisor fits in six bits, so the
          // top bits of the dividend go straight into the remainder.
          rem_nxt   = {1'b0, sample, 10'd0};
          dvd_nxt   = '0;
          quo_nxt   = '0;
          dvs_nxt   = bws_pkg::Q_DIVISOR;
          cnt_nxt   = '0;
          state_nxt = C_RATE;
        end
      end
      C_RATE: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[30:0], 1'b0};
        quo_nxt = quo_step;
        cnt_nxt = 5'(cnt_r + 5'd1);
        if (cnt_r == 5'(bws_pkg::RATE_STEPS - 1)) begin
          rate_nxt  = rate_step;
          rem_nxt   = '0;
          dvd_nxt   = bws_pkg::PERIOD_NUM_Q;
          quo_nxt   = '0;
          dvs_nxt   = {13'd0, rate_step};
          cnt_nxt   = '0;
          state_nxt = C_PERIOD;
        end
      end
      C_PERIOD: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[30:0], 1'b0};
        quo_nxt = quo_step;
        cnt_nxt = 5'(cnt_r + 5'd1);
        if (cnt_r == 5'(bws_pkg::PERIOD_STEPS - 1)) begin
          acc_rise_nxt = '0;
          acc_plat_nxt = '0;
          acc_fall_nxt = '0;
          acc_paus_nxt = '0;
          cnt_nxt      = '0;
          state_nxt    = C_MUL;
        end
      end
      C_MUL: begin
        acc_rise_nxt = mul_step(acc_rise_r, per, bws_pkg::Q_RISE[bit_idx]);
        acc_plat_nxt = mul_step(acc_plat_r, per, bws_pkg::Q_PLATEAU[bit_idx]);
        acc_fall_nxt = mul_step(acc_fall_r, per, bws_pkg::Q_FALL[bit_idx]);
        acc_paus_nxt = mul_step(acc_paus_r, per, bws_pkg::Q_PAUSE[bit_idx]);
        cnt_nxt      = 5'(cnt_r + 5'd1);
        if (cnt_r == 5'(bws_pkg::MUL_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    rate_r     <= rate_nxt;
    acc_rise_r <= acc_rise_nxt;
    acc_plat_r <= acc_plat_nxt;
    acc_fall_r <= acc_fall_nxt;
    acc_paus_r <= acc_paus_nxt;
  end

  // The accumulators hold the product over 2^15; the hold is a further 17-bit shift.
  assign done                = done_r;
  assign holds.rate          = rate_r;
  assign holds.rise_step_ms  = acc_rise_r[23:17];
  assign holds.plateau_ms    = acc_plat_r[26:17];
  assign holds.fall_step_ms  = acc_fall_r[24:17];
  assign holds.pause_ms      = acc_paus_r[27:17];

endmodule

// File: rtl/breath_waveform_sequencer_top.sv
// Breath waveform sequencer top level: handshakes, waveform state and result queue.
// Depends on bws_pkg and bws_start_calc.
// A tick, stop or unused code puts its result in the output register, or in the skid
// entry while that register is held. A start's result waits for the bit-serial divider
// (6 rate steps, 32 period steps) and the 15-step multiplier. Throughput: one tick or
// stop per cycle unless the skid entry is full; a start stalls the input until done.
// Reset (synchronous, active low) clears phase, hold times, rate and both queue entries.
module breath_waveform_sequencer_top #(
  parameter logic [5:0] DUTY_LOW  = bws_pkg::DUTY_LOW_DEF,
  parameter logic [5:0] DUTY_HIGH = bws_pkg::DUTY_HIGH_DEF,
  parameter logic [5:0] DUTY_DROP = bws_pkg::DUTY_DROP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bws_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bws_pkg::out_item_t out_item
);

  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  duty_r, duty_nxt;
  logic [10:0] ms_left_r, ms_left_nxt;
  logic [6:0]  rise_r, rise_nxt;
  logic [9:0]  plat_r, plat_nxt;
  logic [7:0]  fall_r, fall_nxt;
  logic [10:0] pause_r, pause_nxt;
  logic [5:0]  rate_r, rate_nxt;
  logic        busy_r, busy_nxt;

  logic               out_valid_r, skid_valid_r;
  bws_pkg::out_item_t out_r, skid_r, result;

  logic               in_take, is_start, calc_done, push, pop;
  bws_pkg::hold_set_t holds;

  assign in_stall = busy_r || skid_valid_r;
  assign in_take  = in_valid && !in_stall;
  assign is_start = in_take && (in_item.func == bws_pkg::FN_START);

  bws_start_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (is_start),
    .sample (in_item.knob_sample),
    .done   (calc_done),
    .holds  (holds)
  );

  // Waveform state update for ticks, stops and finished starts.
  always_comb begin
    phase_nxt   = phase_r;
    duty_nxt    = duty_r;
    ms_left_nxt = ms_left_r;
    rise_nxt    = rise_r;
    plat_nxt    = plat_r;
    fall_nxt    = fall_r;
    pause_nxt   = pause_r;
    rate_nxt    = rate_r;
    busy_nxt    = busy_r;
    if (calc_done) begin
      busy_nxt    = 1'b0;
      rate_nxt    = holds.rate;
      rise_nxt    = holds.rise_step_ms;
      plat_nxt    = holds.plateau_ms;
      fall_nxt    = holds.fall_step_ms;
      pause_nxt   = holds.pause_ms;
      phase_nxt   = bws_pkg::PH_RISE;
      duty_nxt    = DUTY_LOW;
      ms_left_nxt = {4'd0, holds.rise_step_ms};
    end else if (in_take) begin
      case (in_item.func)
        bws_pkg::FN_TICK: begin
          if (phase_r != bws_pkg::PH_IDLE) begin
            if (ms_left_r > 11'd1) begin
              ms_left_nxt = 11'(ms_left_r - 11'd1);
            end else begin
              unique case (phase_r)
                bws_pkg::PH_RISE: begin
                  if (duty_r < DUTY_HIGH) begin
                    duty_nxt    = 6'(duty_r + 6'd1);
                    ms_left_nxt = {4'd0, rise_r};
                  end else begin
                    phase_nxt   = bws_pkg::PH_PLATEAU;
                    ms_left_nxt = {1'b0, plat_r};
                  end
                end
                bws_pkg::PH_PLATEAU: begin
                  duty_nxt    = DUTY_DROP;
                  phase_nxt   = bws_pkg::PH_FALL;
                  ms_left_nxt = {3'd0, fall_r};
                end
                bws_pkg::PH_FALL: begin
                  if (duty_r > DUTY_LOW) begin
                    duty_nxt    = 6'(duty_r - 6'd1);
                    ms_left_nxt = {3'd0, fall_r};
                  end else begin
                    phase_nxt   = bws_pkg::PH_PAUSE;
                    ms_left_nxt = pause_r;
                  end
                end
                bws_pkg::PH_PAUSE: begin
                  duty_nxt    = DUTY_LOW;
                  phase_nxt   = bws_pkg::PH_RISE;
                  ms_left_nxt = {4'd0, rise_r};
                end
                default: phase_nxt = bws_pkg::PH_IDLE;
              endcase
            end
          end
        end
        bws_pkg::FN_START: begin
          busy_nxt = 1'b1;
        end
        bws_pkg::FN_STOP: begin
          phase_nxt   = bws_pkg::PH_IDLE;
          duty_nxt    = DUTY_LOW;
          ms_left_nxt = '0;
        end
        default: begin
          // Unused code: state unchanged, result reports it.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= bws_pkg::PH_IDLE;
      duty_r    <= DUTY_LOW;
      ms_left_r <= '0;
      rise_r    <= '0;
      plat_r    <= '0;
      fall_r    <= '0;
      pause_r   <= '0;
      rate_r    <= '0;
      busy_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      duty_r    <= duty_nxt;
      ms_left_r <= ms_left_nxt;
      rise_r    <= rise_nxt;
      plat_r    <= plat_nxt;
      fall_r    <= fall_nxt;
      pause_r   <= pause_nxt;
      rate_r    <= rate_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // Result item from the updated state.
  always_comb begin
    result.duty        = duty_nxt;
    result.running     = (phase_nxt != bws_pkg::PH_IDLE);
    result.phase       = phase_nxt;
    result.breath_rate = rate_nxt;
  end

  assign push = (in_take && !is_start) || calc_done;
  assign pop  = out_valid_r && !out_stall;

  // Two-entry result queue: output register plus skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop && skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_r <= skid_r;
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for breath_waveform_sequencer_top: directed and random ticks,
// starts and stops, with random idling on both channels and a built-in waveform predictor.
// Depends on bws_pkg and the sequencer RTL.
module tb_top;

  typedef longint unsigned u64_t;

  // Function code that the block does not decode; its state stays unchanged.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // Stimulus size, quiet tail and watchdog limit.
  localparam int RANDOM_ITEMS = 1180;
  localparam int TAIL_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 2000;

  // Q16 constants of the start computation.
  localparam u64_t KNOB_DIV    = 64'd439779;
  localparam u64_t PERIOD_MS_Q = 64'd60000 << 16;
  localparam u64_t F_RISE      = 64'd809;
  localparam u64_t F_PLATEAU   = 64'd9175;
  localparam u64_t F_FALL      = 64'd2902;
  localparam u64_t F_PAUSE     = 64'd17039;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bws_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bws_pkg::out_item_t out_item;

  // Items waiting to be sent and results waiting to arrive.
  bws_pkg::in_item_t  pending_items[$];
  bws_pkg::out_item_t expected_results[$];
  bws_pkg::out_item_t want_item;

  // Predicted waveform state.
  logic [2:0]  wf_phase;
  logic [5:0]  wf_duty;
  logic [10:0] wf_left;
  logic [6:0]  wf_rise;
  logic [9:0]  wf_plateau;
  logic [7:0]  wf_fall;
  logic [10:0] wf_pause;
  logic [5:0]  wf_rate;

  int in_gap;
  int out_hold;
  int quiet_cycles;
  int fail_count;
  int n_start, n_stop, n_tick, n_unused, n_results, n_breaths;

  breath_waveform_sequencer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Whole milliseconds of a hold: period times factor, both Q16, truncated.
  function automatic u64_t hold_ms(u64_t period_q, u64_t factor);
    u64_t prod;
    prod = period_q * factor;
    return prod >> 32;
  endfunction

  // Applies one accepted item to the predicted waveform and returns the expected result.
  function automatic bws_pkg::out_item_t breath_predict(bws_pkg::in_item_t it);
    u64_t rate_q;
    u64_t period_q;
    u64_t hold;
    bws_pkg::out_item_t res;
    case (it.func)
      bws_pkg::FN_TICK: begin
        if (wf_phase != bws_pkg::PH_IDLE) begin
          if (wf_left > 11'd1) begin
            wf_left = wf_left - 11'd1;
          end else begin
            // The count ran out: the next step starts on this tick.
            case (wf_phase)
              bws_pkg::PH_RISE: begin
                if (wf_duty < bws_pkg::DUTY_HIGH_DEF) begin
                  wf_duty = wf_duty + 6'd1;
                  wf_left = 11'(wf_rise);
                end else begin
                  wf_phase = bws_pkg::PH_PLATEAU;
                  wf_left = 11'(wf_plateau);
                end
              end
              bws_pkg::PH_PLATEAU: begin
                wf_duty = bws_pkg::DUTY_DROP_DEF;
                wf_phase = bws_pkg::PH_FALL;
                wf_left = 11'(wf_fall);
              end
              bws_pkg::PH_FALL: begin
                if (wf_duty > bws_pkg::DUTY_LOW_DEF) begin
                  wf_duty = wf_duty - 6'd1;
                  wf_left = 11'(wf_fall);
                end else begin
                  wf_phase = bws_pkg::PH_PAUSE;
                  wf_left = wf_pause;
                end
              end
              bws_pkg::PH_PAUSE: begin
                wf_duty = bws_pkg::DUTY_LOW_DEF;
                wf_phase = bws_pkg::PH_RISE;
                wf_left = 11'(wf_rise);
                n_breaths++;
              end
              default: wf_phase = bws_pkg::PH_IDLE;
            endcase
          end
        end
      end
      bws_pkg::FN_START: begin
        // Rate, period and hold times from the knob sample.
        rate_q = 64'd12 + ((u64_t'(it.knob_sample) << 16) / KNOB_DIV);
        period_q = PERIOD_MS_Q / rate_q;
        wf_rate = rate_q[5:0];
        hold = hold_ms(period_q, F_RISE);
        wf_rise = hold[6:0];
        hold = hold_ms(period_q, F_PLATEAU);
        wf_plateau = hold[9:0];
        hold = hold_ms(period_q, F_FALL);
        wf_fall = hold[7:0];
        hold = hold_ms(period_q, F_PAUSE);
        wf_pause = hold[10:0];
        wf_phase = bws_pkg::PH_RISE;
        wf_duty = bws_pkg::DUTY_LOW_DEF;
        wf_left = 11'(wf_rise);
      end
      bws_pkg::FN_STOP: begin
        wf_phase = bws_pkg::PH_IDLE;
        wf_duty = bws_pkg::DUTY_LOW_DEF;
        wf_left = 11'd0;
      end
      default: ;
    endcase
    res.duty = wf_duty;
    res.running = (wf_phase != bws_pkg::PH_IDLE);
    res.phase = wf_phase;
    res.breath_rate = wf_rate;
    return res;
  endfunction

  function automatic void queue_item(logic [1:0] fn, logic [7:0] sample);
    bws_pkg::in_item_t it;
    it.func = fn;
    it.knob_sample = sample;
    pending_items.push_back(it);
  endfunction

  // Input driver: predicts each accepted item and presents the next one, with idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      wf_phase = bws_pkg::PH_IDLE;
      wf_duty = bws_pkg::DUTY_LOW_DEF;
      wf_left = '0;
      wf_rise = '0;
      wf_plateau = '0;
      wf_fall = '0;
      wf_pause = '0;
      wf_rate = '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(breath_predict(in_item));
        case (in_item.func)
          bws_pkg::FN_TICK:  n_tick++;
          bws_pkg::FN_START: n_start++;
          bws_pkg::FN_STOP:  n_stop++;
          default:           n_unused++;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item: duty %0d phase %0d", out_item.duty, out_item.phase);
          fail_count++;
        end else begin
          want_item = expected_results.pop_front();
          if (out_item.duty !== want_item.duty) begin
            $error("duty: expected %0d, got %0d", want_item.duty, out_item.duty);
            fail_count++;
          end
          if (out_item.running !== want_item.running) begin
            $error("running: expected %0d, got %0d", want_item.running, out_item.running);
            fail_count++;
          end
          if (out_item.phase !== want_item.phase) begin
            $error("phase: expected %0d, got %0d", want_item.phase, out_item.phase);
            fail_count++;
          end
          if (out_item.breath_rate !== want_item.breath_rate) begin
            $error("breath_rate: expected %0d, got %0d", want_item.breath_rate,
                   out_item.breath_rate);
            fail_count++;
          end
        end
      end
      // Stall bursts, none once the stimulus is nearly used up.
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 15) == 0) begin
        out_hold = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int random_count;
    int seq_len;
    int pick;
    int n_any;
    logic [7:0] sample;

    // Directed: idle behavior, unused code, slowest and fastest rates, restart and stop.
    queue_item(bws_pkg::FN_TICK, 8'hFF);
    queue_item(bws_pkg::FN_STOP, 8'h00);
    queue_item(FN_UNUSED, 8'hAA);
    queue_item(bws_pkg::FN_START, 8'h00);
    repeat (3) queue_item(bws_pkg::FN_TICK, 8'h55);
    queue_item(bws_pkg::FN_START, 8'hFF);
    repeat (2) queue_item(bws_pkg::FN_TICK, 8'h00);
    queue_item(FN_UNUSED, 8'h55);
    queue_item(bws_pkg::FN_STOP, 8'hFF);
    queue_item(bws_pkg::FN_TICK, 8'h00);
    queue_item(bws_pkg::FN_START, 8'h80);
    queue_item(bws_pkg::FN_TICK, 8'h7F);
    queue_item(bws_pkg::FN_START, 8'h06);
    queue_item(bws_pkg::FN_START, 8'h07);
    queue_item(bws_pkg::FN_TICK, 8'h01);
    queue_item(bws_pkg::FN_STOP, 8'h00);
    queue_item(bws_pkg::FN_STOP, 8'h00);

    // The fastest breath takes 1154 ticks, so this wraps from the pause back into the rise.
    queue_item(bws_pkg::FN_START, 8'hFF);
    repeat (1160) queue_item(bws_pkg::FN_TICK, 8'($urandom));
    random_count = 1161;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        // A start with random content, then a run of ticks with a few stray items.
        sample = $urandom_range(0, 1) ? 8'($urandom_range(200, 255)) : 8'($urandom);
        queue_item(bws_pkg::FN_START, sample);
        seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        for (int k = 0; k < seq_len; k++) begin
          pick = $urandom_range(0, 49);
          if (pick == 0) begin
            queue_item(bws_pkg::FN_STOP, 8'($urandom));
          end else if (pick == 1) begin
            queue_item(FN_UNUSED, 8'($urandom));
          end else if (pick == 2) begin
            queue_item(bws_pkg::FN_START, 8'($urandom));
          end else begin
            queue_item(bws_pkg::FN_TICK, 8'($urandom));
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_item(bws_pkg::FN_STOP, 8'($urandom));
        end
        random_count += seq_len + 2;
      end else begin
        // A few items of any code.
        n_any = $urandom_range(1, 5);
        repeat (n_any) queue_item(2'($urandom), 8'($urandom));
        random_count += n_any;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to be sent and its result to arrive.
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d starts, %0d stops, %0d ticks, %0d unused codes.",
             n_results, n_start, n_stop, n_tick, n_unused);
    $display("Predicted %0d complete breaths; %0d mismatches.", n_breaths, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
